// File: rtl/heat_diffusion_stencil_defines.svh
// Assertion macros used by the heat diffusion stencil top level.
`ifndef HEAT_DIFFUSION_STENCIL_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("heat_diffusion_stencil: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("heat_diffusion_stencil: next-cycle check failed");

`endif

// File: rtl/hds_pkg.sv
// Shared constants, types and helpers of the heat diffusion stencil.
package hds_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxRows   = 1024;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxRows);
  localparam int TempBits  = 32;
  localparam int WFrac     = 16;
  localparam int DimW      = 11;
  localparam int SeenW     = 21;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int MinDim    = 3;
  localparam int DiffW     = TempBits + 2;
  localparam int ProdW     = DiffW + WFrac + 1;
  localparam int AccW      = ProdW + 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWeightX = 2'd0,
    CfgWeightY = 2'd1,
    CfgGridW   = 2'd2,
    CfgGridH   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TempBits-1:0] c;
    logic signed [DiffW-1:0]    dx;
    logic signed [DiffW-1:0]    dy;
    logic                       boundary;
    logic                       last;
  } upd_req_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    if (v < DimW'(MinDim)) begin
      r = DimW'(MinDim);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/hds_update.sv
// Arithmetic pipeline: weighted five-point update, rounding and saturation.
module hds_update (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_valid_i,
  input  hds_pkg::upd_req_t                    req_i,
  output logic                                 req_ready_o,
  input  logic [hds_pkg::WFrac-1:0]            weight_x_i,
  input  logic [hds_pkg::WFrac-1:0]            weight_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [hds_pkg::TempBits-1:0]  new_temp_o,
  output logic                                 frame_end_o
);
  import hds_pkg::*;

  logic                       a_valid_q;
  upd_req_t                   a_q;
  logic                       b_valid_q;
  logic signed [ProdW-1:0]    px_q, py_q;
  logic signed [TempBits-1:0] c_b_q;
  logic                       bnd_b_q, last_b_q;
  logic                       out_valid_q;
  logic signed [TempBits-1:0] new_temp_q;
  logic                       frame_end_q;

  logic                       out_free, b_free, a_free;
  logic signed [ProdW-1:0]    px_d, py_d;
  logic signed [AccW-1:0]     acc, quo;
  logic                       ovf;
  logic signed [TempBits-1:0] res;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign b_free      = !b_valid_q || out_free;
  assign a_free      = !a_valid_q || b_free;
  assign req_ready_o = a_free;

  assign px_d = a_q.dx * $signed({1'b0, weight_x_i});
  assign py_d = a_q.dy * $signed({1'b0, weight_y_i});

  // c in Q.WFrac plus both weighted differences, then round half up
  assign acc = (AccW'(c_b_q) <<< WFrac) + AccW'(px_q) + AccW'(py_q)
             + (AccW'(1) <<< (WFrac - 1));
  assign quo = acc >>> WFrac;
  assign ovf = (quo[AccW-1:TempBits-1] != '0) && (quo[AccW-1:TempBits-1] != '1);

  always_comb begin
    if (bnd_b_q) begin
      res = c_b_q;
    end else if (ovf) begin
      res = quo[AccW-1] ? {1'b1, {(TempBits-1){1'b0}}} : {1'b0, {(TempBits-1){1'b1}}};
    end else begin
      res = quo[TempBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_free) a_valid_q <= req_valid_i;
      if (b_free) b_valid_q <= a_valid_q;
      if (out_free) out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free && req_valid_i) begin
      a_q <= req_i;
    end
    if (b_free && a_valid_q) begin
      px_q     <= px_d;
      py_q     <= py_d;
      c_b_q    <= a_q.c;
      bnd_b_q  <= a_q.boundary;
      last_b_q <= a_q.last;
    end
    if (out_free && b_valid_q) begin
      new_temp_q  <= res;
      frame_end_q <= last_b_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_temp_o  = new_temp_q;
  assign frame_end_o = frame_end_q;

endmodule

// File: rtl/heat_diffusion_stencil.sv
// Top level of the heat diffusion stencil: config, counters, line stores, window.
//
// One explicit heat-equation step on a grid streamed in raster order.
// Input channel (in_valid_i / in_stall_o): op_i = 0 carries the next sample
// in temp_in_i (signed Q16.16); op_i = 1 is a flush item that drains one
// lagged result once all samples of the frame have arrived.
// Output channel (out_valid_o / out_stall_i): new_temp_o is the updated
// cell, frame_end_o marks the last cell of the grid. A result belongs to
// the cell one row plus one cell behind the stream, so the first
// grid_width + 1 items of a frame give none.
// Throughput: one item per cycle while in_stall_o is low; each line store takes
// one read and one write per item. An accepted item passes the read stage and
// then the arithmetic pipe before the result that it causes appears.
// Reset: config returns to its defaults and a clearing pass over every entry
// zeroes both line stores; in_stall_o stays high during that pass while
// config writes are still taken.
// A stalled receiver holds the output register; the three-stage arithmetic
// pipe keeps filling and in_stall_o rises only when it is full. Config is to be
// written by the user with cfg_we_i, cfg_index_i and cfg_wdata_i while idle; the block does not enforce it.
module heat_diffusion_stencil (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hds_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [hds_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 op_i,
  input  logic signed [hds_pkg::TempBits-1:0]  temp_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [hds_pkg::TempBits-1:0]  new_temp_o,
  output logic                                 frame_end_o
);
  import hds_pkg::*;
  `include "heat_diffusion_stencil_defines.svh"

  // configuration
  logic [WFrac-1:0] weight_x_q, weight_y_q;
  logic [DimW-1:0]  grid_width_q, grid_height_q;

  // stream position
  logic [AddrW-1:0] line_addr_q, line_addr_d;
  logic [SeenW-1:0] seen_q, seen_d;
  logic [AddrW-1:0] col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;

  // clearing pass
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  // line stores
  logic signed [TempBits-1:0] upper_mem  [MaxWidth];
  logic signed [TempBits-1:0] middle_mem [MaxWidth];
  logic signed [TempBits-1:0] up_rd_q, mid_rd_q;

  // stage after the line store read
  logic                       v1_q;
  logic signed [TempBits-1:0] value1_q;
  logic                       produce1_q, bnd1_q, last1_q;
  logic [AddrW-1:0]           addr1_q;

  // window: centre, right, up-next, down; left and up come from the cells
  // that shift out of centre and up-next
  logic signed [TempBits-1:0] win_c_q, win_r_q, win_un_q, win_d_q;

  logic [DimW-1:0]            w, h;
  logic [2*DimW-1:0]          total;
  logic                       in_acc, complete, ignore, take, produce;
  logic                       bnd, last;
  logic signed [TempBits-1:0] value;
  logic [AddrW-1:0]           addr_cur;
  logic [SeenW-1:0]           seen_inc;
  logic [DimW-1:0]            col_inc;
  logic                       s1_free, s1_adv, upd_ready;
  logic                       upd_ready_w;
  upd_req_t                   upd_req;

  assign w     = clamp_dim(grid_width_q, DimW'(MaxWidth));
  assign h     = clamp_dim(grid_height_q, DimW'(MaxRows));
  assign total = w * h;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign complete = {1'b0, seen_q} >= total;
  assign ignore   = op_i && !complete;
  assign take     = in_acc && !ignore;
  assign value    = (!op_i && !complete) ? temp_in_i : '0;

  assign addr_cur = ({1'b0, line_addr_q} >= w) ? '0 : line_addr_q;
  assign seen_inc = (seen_q == '1) ? seen_q : seen_q + SeenW'(1);
  assign produce  = seen_inc > SeenW'(w + DimW'(1));

  assign bnd  = (col_q == '0) || (row_q == '0) || ({1'b0, col_q} >= w - DimW'(1))
             || ({1'b0, row_q} >= h - DimW'(1));
  assign last = ({1'b0, col_q} >= w - DimW'(1)) && ({1'b0, row_q} >= h - DimW'(1));
  assign col_inc = {1'b0, col_q} + DimW'(1);

  always_comb begin
    line_addr_d = line_addr_q;
    seen_d      = seen_q;
    col_d       = col_q;
    row_d       = row_q;
    if (take) begin
      line_addr_d = ({1'b0, addr_cur} + DimW'(1) >= w) ? '0 : addr_cur + AddrW'(1);
      seen_d      = seen_inc;
      if (produce) begin
        if (last) begin
          col_d  = '0;
          row_d  = '0;
          seen_d = '0;
        end else if (col_inc >= w) begin
          col_d = '0;
          if (row_q != RowW'(MaxRows - 1)) row_d = row_q + RowW'(1);
        end else begin
          col_d = col_inc[AddrW-1:0];
        end
      end
    end
  end

  // hold the read stage unless it retires or the arithmetic pipe takes it
  assign upd_ready  = upd_ready_w;
  assign s1_free    = !v1_q || !produce1_q || upd_ready;
  assign s1_adv     = v1_q && s1_free;
  assign in_stall_o = clr_busy_q || !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_x_q    <= WFrac'(1 << (WFrac - 2));
      weight_y_q    <= WFrac'(1 << (WFrac - 2));
      grid_width_q  <= DimW'(MaxWidth);
      grid_height_q <= DimW'(MaxRows);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgWeightX: weight_x_q    <= cfg_wdata_i[WFrac-1:0];
        CfgWeightY: weight_y_q    <= cfg_wdata_i[WFrac-1:0];
        CfgGridW:   grid_width_q  <= cfg_wdata_i[DimW-1:0];
        CfgGridH:   grid_height_q <= cfg_wdata_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_addr_q <= '0;
      seen_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      v1_q        <= 1'b0;
      win_c_q     <= '0;
      win_r_q     <= '0;
      win_un_q    <= '0;
      win_d_q     <= '0;
    end else begin
      line_addr_q <= line_addr_d;
      seen_q      <= seen_d;
      col_q       <= col_d;
      row_q       <= row_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(MaxWidth - 1)) clr_busy_q <= 1'b0;
      end
      if (take) begin
        v1_q <= 1'b1;
      end else if (s1_adv) begin
        v1_q <= 1'b0;
      end
      if (s1_adv) begin
        win_c_q  <= win_r_q;
        win_r_q  <= mid_rd_q;
        win_un_q <= up_rd_q;
        win_d_q  <= value1_q;
      end
    end
  end

  // line stores: read old data, middle written with the new sample,
  // upper written when the read stage advances, with the middle data just read
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      upper_mem[clr_addr_q]  <= '0;
      middle_mem[clr_addr_q] <= '0;
    end else begin
      if (take) begin
        up_rd_q              <= upper_mem[addr_cur];
        mid_rd_q             <= middle_mem[addr_cur];
        middle_mem[addr_cur] <= value;
      end
      if (s1_adv) begin
        upper_mem[addr1_q] <= mid_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      value1_q   <= value;
      produce1_q <= produce;
      bnd1_q     <= bnd;
      last1_q    <= last;
      addr1_q    <= addr_cur;
    end
  end

  // after the shift: centre is the old right, left the old centre, right the
  // fresh middle read, up the old up-next and down the previous sample
  assign upd_req.c        = win_r_q;
  assign upd_req.dx       = DiffW'(win_c_q) + DiffW'(mid_rd_q) - (DiffW'(win_r_q) <<< 1);
  assign upd_req.dy       = DiffW'(win_un_q) + DiffW'(win_d_q) - (DiffW'(win_r_q) <<< 1);
  assign upd_req.boundary = bnd1_q;
  assign upd_req.last     = last1_q;

  hds_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (v1_q && produce1_q),
    .req_i       (upd_req),
    .req_ready_o (upd_ready_w),
    .weight_x_i  (weight_x_q),
    .weight_y_i  (weight_y_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .new_temp_o  (new_temp_o),
    .frame_end_o (frame_end_o)
  );

  `HDS_ASSERT_NOW(a_clear_empty, clr_busy_q, !v1_q)
  `HDS_ASSERT_NEXT(a_s1_held, v1_q && !s1_free, v1_q)
  `HDS_ASSERT_NEXT(a_frame_restart, take && produce && last,
                   col_q == '0 && row_q == '0 && seen_q == '0)

endmodule

// File: test/heat_diffusion_stencil_tb.sv
// Self-checking testbench of the heat diffusion stencil: directed and random grids.
module heat_diffusion_stencil_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hds_pkg::*;

  localparam logic   OpSample     = 1'b0;
  localparam logic   OpFlush      = 1'b1;
  localparam int     CycleLimit   = 400_000;
  localparam int     TotalItems   = 550;
  localparam int     RandomItems  = 400;
  localparam int     SettleCycles = 8;
  localparam longint TempMax      = 64'sd2147483647;
  localparam longint TempMin      = -64'sd2147483648;
  localparam int unsigned SeenMax = (1 << SeenW) - 1;

  typedef struct packed {
    logic signed [TempBits-1:0] temp;
    logic                       last;
  } cell_t;

  logic                       clk_i = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  cfg_reg_e                   cfg_index = CfgWeightX;
  logic [CfgDataW-1:0]        cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       op_in = OpSample;
  logic signed [TempBits-1:0] temp_in = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [TempBits-1:0] new_temp;
  logic                       frame_end;

  heat_diffusion_stencil dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op_in),
    .temp_in_i   (temp_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .new_temp_o  (new_temp),
    .frame_end_o (frame_end)
  );

  // Mirror of the block: registers, line stores, window and counters
  logic [15:0]     wx, wy;
  logic [DimW-1:0] gw, gh;
  longint          upper_row [MaxWidth];
  longint          middle_row [MaxWidth];
  longint          win_left, win_centre, win_right, win_up_next, win_up, win_down;
  int unsigned     col_cnt, row_cnt, frame_seen, line_addr;
  bit              frame_done;

  cell_t expected_cells[$];
  int    errors = 0;
  int    cycle_count = 0;
  int    counted_items = 0;
  int    sent_items = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    cell_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual new_temp %0d frame_end %0b",
                 $time, new_temp, frame_end);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (new_temp !== want.temp) begin
          $display("%0t: new_temp mismatch: expected %0d actual %0d",
                   $time, want.temp, new_temp);
          errors++;
        end
        if (frame_end !== want.last) begin
          $display("%0t: frame_end mismatch: expected %0b actual %0b",
                   $time, want.last, frame_end);
          errors++;
        end
      end
    end
  end

  function automatic void reset_mirror();
    wx = 16'd16384;
    wy = 16'd16384;
    gw = DimW'(MaxWidth);
    gh = DimW'(MaxRows);
    for (int i = 0; i < MaxWidth; i++) begin
      upper_row[i]  = 0;
      middle_row[i] = 0;
    end
    win_left = 0; win_centre = 0; win_right = 0;
    win_up_next = 0; win_up = 0; win_down = 0;
    col_cnt = 0; row_cnt = 0; frame_seen = 0; line_addr = 0;
    frame_done = 1'b0;
  endfunction

  function automatic int unsigned dim_in_use(logic [DimW-1:0] v, int unsigned hi);
    if (v < MinDim) return MinDim;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned frame_total();
    return dim_in_use(gw, MaxWidth) * dim_in_use(gh, MaxRows);
  endfunction

  // Explicit update, rounded half up and clamped to the signed sample range
  function automatic logic signed [TempBits-1:0] diffuse(longint c, longint l, longint r,
                                                         longint u, longint d);
    longint dx, dy, acc, q;
    dx  = l + r - 2 * c;
    dy  = u + d - 2 * c;
    acc = c * 65536 + dx * longint'({48'd0, wx}) + dy * longint'({48'd0, wy});
    q   = (acc + 32768) >>> WFrac;
    if (q > TempMax) q = TempMax;
    else if (q < TempMin) q = TempMin;
    return q[TempBits-1:0];
  endfunction

  function automatic void predict_cell(input logic op, input logic signed [TempBits-1:0] temp,
                                       output bit used);
    int unsigned w, h, col, row;
    longint      value, up_rd, mid_rd;
    bit          complete, last;
    logic signed [TempBits-1:0] res;
    w = dim_in_use(gw, MaxWidth);
    h = dim_in_use(gh, MaxRows);
    complete = frame_seen >= w * h;
    used = 1'b1;
    // drop flush items while the grid is still coming in
    if (op == OpFlush && !complete) begin
      used = 1'b0;
      return;
    end
    value = (op == OpSample && !complete) ? longint'(temp) : 0;

    if (line_addr >= w) line_addr = 0;
    up_rd  = upper_row[line_addr];
    mid_rd = middle_row[line_addr];
    upper_row[line_addr]  = mid_rd;
    middle_row[line_addr] = value;
    line_addr = (line_addr + 1 >= w) ? 0 : line_addr + 1;

    win_left    = win_centre;
    win_centre  = win_right;
    win_right   = mid_rd;
    win_up      = win_up_next;
    win_up_next = up_rd;

    if (frame_seen < SeenMax) frame_seen++;
    if (frame_seen <= w + 1) begin
      win_down = value;
      return;
    end

    col = col_cnt;
    row = row_cnt;
    if (col == 0 || row == 0 || col >= w - 1 || row >= h - 1)
      res = win_centre[TempBits-1:0];
    else
      res = diffuse(win_centre, win_left, win_right, win_up, win_down);
    win_down = value;

    last = (col >= w - 1) && (row >= h - 1);
    expected_cells.push_back('{temp: res, last: last});
    frame_done = last;

    if (last) begin
      col_cnt = 0;
      row_cnt = 0;
      frame_seen = 0;
    end else begin
      col++;
      if (col >= w) begin
        col = 0;
        if (row < MaxRows - 1) row++;
      end
      col_cnt = col;
      row_cnt = row;
    end
  endfunction

  function automatic logic signed [TempBits-1:0] random_temp();
    case ($urandom_range(3))
      0: return $urandom;
      3: begin
        case ($urandom_range(3))
          0: return 32'sh7FFFFFFF;
          1: return 32'sh80000000;
          2: return 32'sh00000000;
          default: return 32'shFFFFFFFF;
        endcase
      end
      default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    endcase
  endfunction

  function automatic logic [15:0] random_weight();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // first third: sender idles lightly, receiver heavily; then swapped; then none
  task automatic next_idling();
    if (sent_items < TotalItems / 3) begin
      send_idle_pct = 15; recv_stall_pct = 63;
    end else if (sent_items < 2 * TotalItems / 3) begin
      send_idle_pct = 63; recv_stall_pct = 15;
    end else begin
      send_idle_pct = 0; recv_stall_pct = 0;
    end
  endtask

  task automatic send_item(input logic op, input logic signed [TempBits-1:0] temp);
    bit used;
    next_idling();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op_in    <= op;
    temp_in  <= temp;
    do @(posedge clk_i); while (in_stall);
    sent_items++;
    predict_cell(op, temp, used);
    if (used) counted_items++;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    // flush items still in the pipe give no result, so let it settle
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      CfgWeightX: wx = val;
      CfgWeightY: wy = val;
      CfgGridW:   gw = val[DimW-1:0];
      CfgGridH:   gh = val[DimW-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Unused upper data bits carry noise on the size registers
  task automatic configure(logic [15:0] wx_v, logic [15:0] wy_v,
                           logic [DimW-1:0] w_v, logic [DimW-1:0] h_v);
    wait_results_done();
    write_reg(CfgWeightX, wx_v);
    write_reg(CfgWeightY, wy_v);
    write_reg(CfgGridW, {5'($urandom), w_v});
    write_reg(CfgGridH, {5'($urandom), h_v});
  endtask

  task automatic run_frame(bit noisy);
    frame_done = 1'b0;
    while (frame_seen < frame_total()) begin
      if (noisy && $urandom_range(99) < 8) send_item(OpFlush, $urandom);
      send_item(OpSample, random_temp());
    end
    // drain the lag; a late sample acts as a flush
    do begin
      if (noisy && $urandom_range(99) < 20) send_item(OpSample, random_temp());
      else send_item(OpFlush, $urandom);
    end while (!frame_done);
  endtask

  task automatic partial_frame();
    int unsigned remaining;
    remaining = frame_total() - frame_seen;
    if (remaining > 1) begin
      repeat ($urandom_range(1, remaining - 1)) send_item(OpSample, random_temp());
    end
  endtask

  task automatic test_directed_extremes();
    logic signed [TempBits-1:0] cells [12] = '{
      32'sh00000000, 32'sh7FFFFFFF, 32'sh80000000, 32'shFFFFFFFF,
      32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
      32'sh00000001, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000};
    wait_results_done();
    // weights stay at their reset values; both inner cells reach the limits of the sample range
    write_reg(CfgGridW, 16'd4);
    write_reg(CfgGridH, 16'd3);
    send_item(OpFlush, 32'sh7FFFFFFF);
    foreach (cells[i]) send_item(OpSample, cells[i]);
    send_item(OpSample, 32'sh12345678);
    while (!frame_done) send_item(OpFlush, 32'sh00000000);
  endtask

  task automatic test_weight_extremes();
    configure(16'h0000, 16'h0000, 11'd5, 11'd4);
    run_frame(1'b0);
    configure(16'hFFFF, 16'hFFFF, 11'd4, 11'd5);
    run_frame(1'b0);
    configure(16'h0000, 16'hFFFF, 11'd6, 11'd3);
    run_frame(1'b1);
  endtask

  task automatic test_size_extremes();
    // oversize sizes clamp to the full line store; shrink the grid mid-frame
    configure(random_weight(), random_weight(), 11'd2047, 11'd2047);
    repeat (30) send_item(OpSample, random_temp());
    configure(random_weight(), random_weight(), 11'd5, 11'd4);
    run_frame(1'b1);
    // zero sizes clamp to the minimum grid
    configure(random_weight(), random_weight(), 11'd0, 11'd0);
    run_frame(1'b1);
  endtask

  task automatic test_random_frames();
    counted_items = 0;
    while (counted_items < RandomItems) begin
      configure(random_weight(), random_weight(),
                11'($urandom_range(0, 12)), 11'($urandom_range(0, 9)));
      repeat ($urandom_range(1, 3)) run_frame(1'b1);
      // leave a frame partly done so the next sizes apply mid-frame
      if ($urandom_range(99) < 25) partial_frame();
    end
  endtask

  initial begin
    reset_mirror();
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    test_directed_extremes();
    test_weight_extremes();
    test_size_extremes();
    test_random_frames();
    wait_results_done();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
